// File: rtl/core/relative_rectangle_placer_unit_macros.svh
// ----------------------------------------------------------------------------
// Relative rectangle placer - assertion macros
// Concurrent assertion helpers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RELATIVE_RECTANGLE_PLACER_UNIT_MACROS_SVH
`define RELATIVE_RECTANGLE_PLACER_UNIT_MACROS_SVH

`ifndef SYNTH
// Implication checked at every rising clock edge outside reset.
`define RRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Invariant checked at every rising clock edge outside reset.
`define RRP_ASSERT_ALW(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);
`else
`define RRP_ASSERT_IMP(lbl, ante, cons, msg)
`define RRP_ASSERT_ALW(lbl, expr, msg)
`endif

`endif

// File: rtl/core/rrp_pkg.sv
// ----------------------------------------------------------------------------
// Relative rectangle placer - shared package
// Field widths, command, status, side and alignment codes, and the slot and compare record types.
// ----------------------------------------------------------------------------
package rrp_pkg;

	localparam int ID_W          = 32;
	localparam int POS_W         = 20;
	localparam int SPAN_W        = 14;
	localparam int MAX_RECTS_DEF = 16;

	// command
	localparam logic OP_CLEAR = 1'b1;

	// result status
	localparam logic [2:0] STAT_ADDED     = 3'd0;
	localparam logic [2:0] STAT_DUP       = 3'd1;
	localparam logic [2:0] STAT_BAD_ALIGN = 3'd2;
	localparam logic [2:0] STAT_NO_REF    = 3'd3;
	localparam logic [2:0] STAT_OVERLAP   = 3'd4;
	localparam logic [2:0] STAT_FULL      = 3'd5;
	localparam logic [2:0] STAT_CLEARED   = 3'd6;

	// placement side
	localparam logic [1:0] SIDE_ABOVE = 2'd0;
	localparam logic [1:0] SIDE_BELOW = 2'd1;
	localparam logic [1:0] SIDE_LEFT  = 2'd2;
	localparam logic [1:0] SIDE_RIGHT = 2'd3;

	// alignment
	localparam logic [1:0] ALIGN_START  = 2'd0;
	localparam logic [1:0] ALIGN_END    = 2'd1;
	localparam logic [1:0] ALIGN_CENTRE = 2'd2;
	localparam logic [1:0] ALIGN_BAD    = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [SPAN_W-1:0] span_x;
		logic [SPAN_W-1:0] span_y;
	} slot_t;

	typedef struct packed {
		logic id_hit;
		logic ref_hit;
		logic ovl_hit;
	} cmp_res_t;

endpackage

// File: rtl/core/rrp_slot_mem.sv
// ----------------------------------------------------------------------------
// Relative rectangle placer - slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrp_slot_mem #(
	parameter int DEPTH = rrp_pkg::MAX_RECTS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  rrp_pkg::slot_t  wr_data,
	input  logic [AW-1:0]   rd_addr,
	output rrp_pkg::slot_t  rd_data
);

	rrp_pkg::slot_t mem_q [DEPTH];
	rrp_pkg::slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/rrp_cmp_unit.sv
// ----------------------------------------------------------------------------
// Relative rectangle placer - shared compare unit
// Tests one stored slot for id match, reference match and overlap.
// ----------------------------------------------------------------------------
module rrp_cmp_unit (
	input  rrp_pkg::slot_t                  entry,
	input  logic [rrp_pkg::ID_W-1:0]        key_id,
	input  logic [rrp_pkg::ID_W-1:0]        ref_id,
	input  logic [rrp_pkg::POS_W-1:0]       new_x,
	input  logic [rrp_pkg::POS_W-1:0]       new_y,
	input  logic [rrp_pkg::SPAN_W-1:0]      new_sx,
	input  logic [rrp_pkg::SPAN_W-1:0]      new_sy,
	output rrp_pkg::cmp_res_t               res
);

	localparam int EW = rrp_pkg::POS_W + 2;
	localparam int ZW = EW - rrp_pkg::SPAN_W;

	logic signed [EW-1:0] ox, oy, oex, oey;
	logic signed [EW-1:0] nx, ny, nex, ney;

	always_comb begin
		ox  = {{2{entry.x[rrp_pkg::POS_W-1]}}, entry.x};
		oy  = {{2{entry.y[rrp_pkg::POS_W-1]}}, entry.y};
		oex = ox + {{ZW{1'b0}}, entry.span_x};
		oey = oy + {{ZW{1'b0}}, entry.span_y};
		nx  = {{2{new_x[rrp_pkg::POS_W-1]}}, new_x};
		ny  = {{2{new_y[rrp_pkg::POS_W-1]}}, new_y};
		nex = nx + {{ZW{1'b0}}, new_sx};
		ney = ny + {{ZW{1'b0}}, new_sy};

		res.id_hit  = (entry.id == key_id);
		res.ref_hit = (entry.id == ref_id);
		// touching edges are not an overlap
		res.ovl_hit = (nex > ox) && (oex > nx) && (ney > oy) && (oey > ny);
	end

endmodule

// File: rtl/core/relative_rectangle_placer_unit.sv
// ----------------------------------------------------------------------------
// Relative rectangle placer - top level
// Keeps a table of placed rectangles and places new ones next to a reference.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one command word: add a
//   rectangle next to a stored reference, or clear the whole table. Response
//   channel (rsp_valid / rsp_stall) returns exactly one result word for every
//   request word: status, placed position, conflicting slot, table fill.
// Sequence of an add (n = slots filled when the word is taken):
//   An add reads one slot per cycle through the single read port and the
//   shared compare unit: id and reference scan over the n filled slots,
//   a placement step, overlap scan over the same slots, result load.
//   Early exits (duplicate, bad alignment, full, missing reference, overlap)
//   cut the sequence short; an add to an empty table stores its entry after
//   the id scan, and a clear goes straight to the result load. The next
//   word can be taken in the cycle after the result loads.
// Reset: arst_n empties the table and drops any pending response.
// Stall: the result waits in the response register while the next word is
//   taken; the engine holds its next result until that register frees up.
// ----------------------------------------------------------------------------
`include "relative_rectangle_placer_unit_macros.svh"

module relative_rectangle_placer_unit #(
	parameter int MAX_RECTS = rrp_pkg::MAX_RECTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             opcode,
	input  logic [rrp_pkg::ID_W-1:0]         rect_id,
	input  logic [rrp_pkg::SPAN_W-1:0]       width,
	input  logic [rrp_pkg::SPAN_W-1:0]       height,
	input  logic [1:0]                       rotation,
	input  logic [rrp_pkg::ID_W-1:0]         reference_id,
	input  logic [1:0]                       side,
	input  logic [1:0]                       alignment,
	// response channel
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [2:0]                       status,
	output logic signed [rrp_pkg::POS_W-1:0] placed_x,
	output logic signed [rrp_pkg::POS_W-1:0] placed_y,
	output logic [3:0]                       conflict_slot,
	output logic [4:0]                       entry_count
);

	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int PW = rrp_pkg::POS_W;
	localparam int SW = rrp_pkg::SPAN_W;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN1 = 3'd1;
	localparam logic [2:0] S_CALC  = 3'd2;
	localparam logic [2:0] S_SCAN2 = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           iss_q;
	logic                    vld_s1;
	logic [AW-1:0]           idx_s1;
	logic                    found_q;

	// latched request
	logic [rrp_pkg::ID_W-1:0] id_q;
	logic [rrp_pkg::ID_W-1:0] ref_id_q;
	logic [SW-1:0]            sx_q, sy_q;
	logic [1:0]               side_q;
	logic [1:0]               align_q;
	rrp_pkg::slot_t           ref_q;
	logic [PW-1:0]            nx_q, ny_q;

	// result waiting for the response register
	logic [2:0]              res_status_q;
	logic [PW-1:0]           res_x_q, res_y_q;
	logic [AW-1:0]           res_slot_q;

	// response register
	logic                    rsp_valid_q;
	logic [2:0]              status_q;
	logic [PW-1:0]           placed_x_q, placed_y_q;
	logic [3:0]              conflict_slot_q;
	logic [4:0]              entry_count_q;

	// scan control
	logic                    scan_active;
	logic                    issue;
	logic                    dup_hit;
	logic                    ovl_hit;
	logic                    scan1_done;
	logic                    scan2_done;
	logic                    wr_en;
	logic                    rsp_load;
	rrp_pkg::slot_t          rd_data;
	rrp_pkg::slot_t          wr_data;
	rrp_pkg::cmp_res_t       cmp;

	// placement arithmetic
	logic                    vert;
	logic                    ahead;
	logic [PW-1:0]           ra, rb;
	logic [SW-1:0]           rsa, rsb, sa, sb;
	logic [SW:0]             diff;
	logic [SW:0]             diff_r;
	logic [SW:0]             half;
	logic [SW:0]             off;
	logic [PW-1:0]           a_pos, b_pos;
	logic [PW-1:0]           calc_x, calc_y;

	assign req_stall   = (state_q != S_IDLE);
	assign scan_active = (state_q == S_SCAN1) || (state_q == S_SCAN2);
	assign issue       = scan_active && (iss_q != count_q);
	assign dup_hit     = (state_q == S_SCAN1) && vld_s1 && cmp.id_hit;
	assign ovl_hit     = (state_q == S_SCAN2) && vld_s1 && cmp.ovl_hit;
	assign scan1_done  = (state_q == S_SCAN1) && !vld_s1 && (iss_q == count_q);
	assign scan2_done  = (state_q == S_SCAN2) && !vld_s1 && (iss_q == count_q);
	assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// store the new slot: the first entry right after the id scan, any other
	// once the overlap scan comes through clean
	assign wr_en = (scan1_done && (align_q != rrp_pkg::ALIGN_BAD) && (count_q == '0))
		|| scan2_done;

	always_comb begin
		wr_data.id     = id_q;
		wr_data.x      = nx_q;
		wr_data.y      = ny_q;
		wr_data.span_x = sx_q;
		wr_data.span_y = sy_q;
	end

	rrp_slot_mem #(
		.DEPTH (MAX_RECTS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_addr (iss_q[AW-1:0]),
		.rd_data (rd_data)
	);

	rrp_cmp_unit u_cmp (
		.entry  (rd_data),
		.key_id (id_q),
		.ref_id (ref_id_q),
		.new_x  (nx_q),
		.new_y  (ny_q),
		.new_sx (sx_q),
		.new_sy (sy_q),
		.res    (cmp)
	);

	// Placement: "a" is the aligned axis, "b" the axis on which the new
	// rectangle abuts the reference. All sums wrap to the position width.
	always_comb begin
		vert   = (side_q == rrp_pkg::SIDE_ABOVE) || (side_q == rrp_pkg::SIDE_BELOW);
		ahead  = (side_q == rrp_pkg::SIDE_ABOVE) || (side_q == rrp_pkg::SIDE_LEFT);
		ra  = vert ? ref_q.x      : ref_q.y;
		rsa = vert ? ref_q.span_x : ref_q.span_y;
		sa  = vert ? sx_q         : sy_q;
		rb  = vert ? ref_q.y      : ref_q.x;
		rsb = vert ? ref_q.span_y : ref_q.span_x;
		sb  = vert ? sy_q         : sx_q;

		diff   = {1'b0, rsa} - {1'b0, sa};
		// halve toward zero: bias negatives by one before the arithmetic shift
		diff_r = diff + {{SW{1'b0}}, diff[SW]};
		half   = {diff_r[SW], diff_r[SW:1]};
		case (align_q)
			rrp_pkg::ALIGN_END:    off = diff;
			rrp_pkg::ALIGN_CENTRE: off = half;
			default:               off = '0;
		endcase
		a_pos = ra + {{(PW-SW-1){off[SW]}}, off};
		b_pos = ahead ? (rb - {{(PW-SW){1'b0}}, sb}) : (rb + {{(PW-SW){1'b0}}, rsb});
		calc_x = vert ? a_pos : b_pos;
		calc_y = vert ? b_pos : a_pos;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			iss_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= issue && !dup_hit && !ovl_hit;
			if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (opcode == rrp_pkg::OP_CLEAR) begin
							count_q <= '0;
							state_q <= S_DONE;
						end else begin
							iss_q   <= '0;
							found_q <= 1'b0;
							state_q <= S_SCAN1;
						end
					end
				end
				S_SCAN1: begin
					if (vld_s1 && cmp.ref_hit && !found_q) begin
						found_q <= 1'b1;
					end
					if (dup_hit) begin
						state_q <= S_DONE;
					end else if (scan1_done) begin
						if (align_q == rrp_pkg::ALIGN_BAD || count_q >= CW'(MAX_RECTS)) begin
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							count_q <= count_q + 1'b1;
							state_q <= S_DONE;
						end else if (!found_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_CALC;
						end
					end
				end
				S_CALC: begin
					iss_q   <= '0;
					state_q <= S_SCAN2;
				end
				S_SCAN2: begin
					if (ovl_hit) begin
						state_q <= S_DONE;
					end else if (scan2_done) begin
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request, reference and result payload: no reset needed
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				id_q     <= rect_id;
				ref_id_q <= reference_id;
				sx_q     <= rotation[0] ? height : width;
				sy_q     <= rotation[0] ? width  : height;
				side_q   <= side;
				align_q  <= alignment;
				nx_q     <= '0;
				ny_q     <= '0;
				res_status_q <= rrp_pkg::STAT_CLEARED;
				res_x_q      <= '0;
				res_y_q      <= '0;
				res_slot_q   <= '0;
			end
			S_SCAN1: begin
				if (vld_s1 && cmp.ref_hit && !found_q) begin
					ref_q <= rd_data;
				end
				if (dup_hit) begin
					res_status_q <= rrp_pkg::STAT_DUP;
				end else if (scan1_done) begin
					if (align_q == rrp_pkg::ALIGN_BAD) begin
						res_status_q <= rrp_pkg::STAT_BAD_ALIGN;
					end else if (count_q >= CW'(MAX_RECTS)) begin
						res_status_q <= rrp_pkg::STAT_FULL;
					end else if (count_q == '0) begin
						res_status_q <= rrp_pkg::STAT_ADDED;
					end else begin
						res_status_q <= rrp_pkg::STAT_NO_REF;
					end
				end
			end
			S_CALC: begin
				nx_q <= calc_x;
				ny_q <= calc_y;
			end
			S_SCAN2: begin
				res_x_q <= nx_q;
				res_y_q <= ny_q;
				if (ovl_hit) begin
					res_status_q <= rrp_pkg::STAT_OVERLAP;
					res_slot_q   <= idx_s1;
				end else begin
					res_status_q <= rrp_pkg::STAT_ADDED;
				end
			end
			default: begin
			end
		endcase
	end

	// response register: hold while stalled, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status_q        <= res_status_q;
			placed_x_q      <= res_x_q;
			placed_y_q      <= res_y_q;
			conflict_slot_q <= 4'(res_slot_q);
			entry_count_q   <= 5'(count_q);
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign placed_x      = placed_x_q;
	assign placed_y      = placed_y_q;
	assign conflict_slot = conflict_slot_q;
	assign entry_count   = entry_count_q;

	// checks
	`RRP_ASSERT_ALW(a_count_range, count_q <= CW'(MAX_RECTS), "fill count beyond table size")
	`RRP_ASSERT_IMP(a_scan_in_table, vld_s1, CW'(idx_s1) < count_q, "scan read past filled slots")
	`RRP_ASSERT_IMP(a_slot_only_overlap, rsp_valid && status != rrp_pkg::STAT_OVERLAP, conflict_slot == 4'd0, "conflict slot set without overlap")

endmodule

// File: dv/tb_relative_rectangle_placer_unit.sv
// ----------------------------------------------------------------------------
// Relative rectangle placer - testbench
// Sends add and clear words to the placer and checks every result word against
// an in-bench predictor of the rectangle table. Directed words cover each
// status but table full, every side and alignment, rotation and the size
// extremes. Random sessions then fill, overflow and clear the table under
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_relative_rectangle_placer_unit;

	localparam int          MAX_RECTS    = rrp_pkg::MAX_RECTS_DEF;
	localparam int          RANDOM_WORDS = 1800;
	// two copies of the table: one steers the generator, one checks the block
	localparam int unsigned PLAN_COPY    = 0;
	localparam int unsigned CHECK_COPY   = 1;

	typedef struct packed {
		logic                       opcode;
		logic [rrp_pkg::ID_W-1:0]   rect_id;
		logic [rrp_pkg::SPAN_W-1:0] width;
		logic [rrp_pkg::SPAN_W-1:0] height;
		logic [1:0]                 rotation;
		logic [rrp_pkg::ID_W-1:0]   ref_id;
		logic [1:0]                 side;
		logic [1:0]                 alignment;
	} placement_req_t;

	typedef struct packed {
		logic [2:0]                       status;
		logic signed [rrp_pkg::POS_W-1:0] placed_x;
		logic signed [rrp_pkg::POS_W-1:0] placed_y;
		logic [3:0]                       conflict_slot;
		logic [4:0]                       entry_count;
	} placement_rsp_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request channel, driven at the falling edge
	logic                       req_valid    = 1'b0;
	logic                       req_stall;
	logic                       opcode       = 1'b0;
	logic [rrp_pkg::ID_W-1:0]   rect_id      = '0;
	logic [rrp_pkg::SPAN_W-1:0] width        = '0;
	logic [rrp_pkg::SPAN_W-1:0] height       = '0;
	logic [1:0]                 rotation     = '0;
	logic [rrp_pkg::ID_W-1:0]   reference_id = '0;
	logic [1:0]                 side         = '0;
	logic [1:0]                 alignment    = '0;

	// response channel
	logic                             rsp_valid;
	logic                             rsp_stall = 1'b0;
	logic [2:0]                       status;
	logic signed [rrp_pkg::POS_W-1:0] placed_x;
	logic signed [rrp_pkg::POS_W-1:0] placed_y;
	logic [3:0]                       conflict_slot;
	logic [4:0]                       entry_count;

	// predictor state: slot table and fill count per copy
	rrp_pkg::slot_t layout[2][MAX_RECTS];
	int unsigned    layout_fill[2] = '{0, 0};

	placement_req_t words_to_send[$];
	placement_rsp_t results_due[$];

	logic        req_taken  = 1'b0;
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;
	int unsigned stall_period = 2;
	int unsigned stall_on   = 1;

	int unsigned mismatches = 0;
	int unsigned words_checked = 0;
	int unsigned seen_status[8];
	int unsigned full_hits  = 0;

	relative_rectangle_placer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.opcode        (opcode),
		.rect_id       (rect_id),
		.width         (width),
		.height        (height),
		.rotation      (rotation),
		.reference_id  (reference_id),
		.side          (side),
		.alignment     (alignment),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.placed_x      (placed_x),
		.placed_y      (placed_y),
		.conflict_slot (conflict_slot),
		.entry_count   (entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one word to the chosen copy of the table and return its result.
	// Check order: duplicate id, bad alignment, full table, missing
	// reference, overlap. Shared edges do not count as overlap.
	function automatic placement_rsp_t place_rectangle(input int unsigned copy,
			input placement_req_t w);
		placement_rsp_t             r;
		rrp_pkg::slot_t             s;
		int                         span_x, span_y, ref_sx, ref_sy;
		int                         rx, ry, nx, ny, ox, oy;
		int unsigned                hit;
		bit                         found;
		logic [rrp_pkg::POS_W-1:0]  px, py;
		r = '0;
		if (w.opcode == rrp_pkg::OP_CLEAR) begin
			layout_fill[copy] = 0;
			r.status = rrp_pkg::STAT_CLEARED;
			return r;
		end
		r.entry_count = 5'(layout_fill[copy]);
		// a quarter turn either way swaps the spans
		if (w.rotation[0]) begin
			span_x = w.height;
			span_y = w.width;
		end else begin
			span_x = w.width;
			span_y = w.height;
		end
		for (int unsigned k = 0; k < layout_fill[copy]; k++) begin
			if (layout[copy][k].id == w.rect_id) begin
				r.status = rrp_pkg::STAT_DUP;
				return r;
			end
		end
		if (w.alignment == rrp_pkg::ALIGN_BAD) begin
			r.status = rrp_pkg::STAT_BAD_ALIGN;
			return r;
		end
		if (layout_fill[copy] >= MAX_RECTS) begin
			r.status = rrp_pkg::STAT_FULL;
			return r;
		end
		px = '0;
		py = '0;
		// the first entry lands at the origin whatever the reference says
		if (layout_fill[copy] != 0) begin
			found = 1'b0;
			hit   = 0;
			for (int unsigned k = 0; k < layout_fill[copy] && !found; k++) begin
				if (layout[copy][k].id == w.ref_id) begin
					hit   = k;
					found = 1'b1;
				end
			end
			if (!found) begin
				r.status = rrp_pkg::STAT_NO_REF;
				return r;
			end
			s      = layout[copy][hit];
			rx     = $signed(s.x);
			ry     = $signed(s.y);
			ref_sx = s.span_x;
			ref_sy = s.span_y;
			// centre offset divides signed, truncating toward zero
			if (w.side == rrp_pkg::SIDE_ABOVE || w.side == rrp_pkg::SIDE_BELOW) begin
				case (w.alignment)
					rrp_pkg::ALIGN_START: nx = rx;
					rrp_pkg::ALIGN_END:   nx = rx + ref_sx - span_x;
					default:              nx = rx + (ref_sx - span_x) / 2;
				endcase
				ny = (w.side == rrp_pkg::SIDE_ABOVE) ? ry - span_y : ry + ref_sy;
			end else begin
				case (w.alignment)
					rrp_pkg::ALIGN_START: ny = ry;
					rrp_pkg::ALIGN_END:   ny = ry + ref_sy - span_y;
					default:              ny = ry + (ref_sy - span_y) / 2;
				endcase
				nx = (w.side == rrp_pkg::SIDE_LEFT) ? rx - span_x : rx + ref_sx;
			end
			// positions wrap to the coordinate width before the overlap test
			px = rrp_pkg::POS_W'(nx);
			py = rrp_pkg::POS_W'(ny);
			nx = $signed(px);
			ny = $signed(py);
			for (int unsigned k = 0; k < layout_fill[copy]; k++) begin
				ox = $signed(layout[copy][k].x);
				oy = $signed(layout[copy][k].y);
				if (nx + span_x > ox && ox + int'(layout[copy][k].span_x) > nx &&
						ny + span_y > oy && oy + int'(layout[copy][k].span_y) > ny) begin
					r.status        = rrp_pkg::STAT_OVERLAP;
					r.placed_x      = px;
					r.placed_y      = py;
					r.conflict_slot = 4'(k);
					return r;
				end
			end
		end
		s.id     = w.rect_id;
		s.x      = px;
		s.y      = py;
		s.span_x = rrp_pkg::SPAN_W'(span_x);
		s.span_y = rrp_pkg::SPAN_W'(span_y);
		layout[copy][layout_fill[copy]] = s;
		layout_fill[copy]++;
		r.status      = rrp_pkg::STAT_ADDED;
		r.placed_x    = px;
		r.placed_y    = py;
		r.entry_count = 5'(layout_fill[copy]);
		return r;
	endfunction

	function automatic placement_req_t make_add(input logic [rrp_pkg::ID_W-1:0] id,
			input int w, input int h, input logic [1:0] rot,
			input logic [rrp_pkg::ID_W-1:0] ref_id, input logic [1:0] sd,
			input logic [1:0] al);
		placement_req_t q;
		q.opcode    = ~rrp_pkg::OP_CLEAR;
		q.rect_id   = id;
		q.width     = rrp_pkg::SPAN_W'(w);
		q.height    = rrp_pkg::SPAN_W'(h);
		q.rotation  = rot;
		q.ref_id    = ref_id;
		q.side      = sd;
		q.alignment = al;
		return q;
	endfunction

	// clear word; the other fields carry noise the block must ignore
	function automatic placement_req_t make_clear();
		placement_req_t q;
		q = make_add($urandom(), $urandom_range(0, 16383), $urandom_range(0, 16383),
			2'($urandom_range(0, 3)), $urandom(), 2'($urandom_range(0, 3)),
			2'($urandom_range(0, 3)));
		q.opcode = rrp_pkg::OP_CLEAR;
		return q;
	endfunction

	// Mostly well-formed adds against a stored reference, small sizes, with
	// some duplicates, bad alignments, unknown references and huge sizes.
	function automatic placement_req_t random_add();
		placement_req_t q;
		int unsigned    fill, pick;
		fill = layout_fill[PLAN_COPY];
		pick = $urandom_range(0, 99);
		q = make_add($urandom(), $urandom_range(1, 48), $urandom_range(1, 48),
			2'($urandom_range(0, 3)), $urandom(), 2'($urandom_range(0, 3)),
			2'($urandom_range(0, 2)));
		if ($urandom_range(0, 9) == 0) begin
			q.width  = rrp_pkg::SPAN_W'($urandom_range(0, 16383));
			q.height = rrp_pkg::SPAN_W'($urandom_range(0, 16383));
		end
		if (fill != 0)
			q.ref_id = layout[PLAN_COPY][$urandom_range(0, fill - 1)].id;
		if (pick < 8 && fill != 0)
			q.rect_id = layout[PLAN_COPY][$urandom_range(0, fill - 1)].id;
		else if (pick < 13)
			q.alignment = rrp_pkg::ALIGN_BAD;
		else if (pick < 18)
			q.ref_id = $urandom();
		return q;
	endfunction

	// queue a word for the driver and advance the planning copy with it
	task automatic schedule_word(input placement_req_t w);
		void'(place_rectangle(PLAN_COPY, w));
		words_to_send = {words_to_send, w};
	endtask

	task automatic compare_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Sender: present words from the queue in bursts of random length with
	// random gaps; hold a stalled word unchanged until it is taken.
	always @(negedge clk) begin
		placement_req_t w;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_taken) begin
			// hold: the current word is still waiting
		end else if (gap_left != 0) begin
			req_valid <= 1'b0;
			gap_left  <= gap_left - 1;
		end else if (words_to_send.size() != 0) begin
			w = words_to_send.pop_front();
			opcode       <= w.opcode;
			rect_id      <= w.rect_id;
			width        <= w.width;
			height       <= w.height;
			rotation     <= w.rotation;
			reference_id <= w.ref_id;
			side         <= w.side;
			alignment    <= w.alignment;
			req_valid    <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 30);
				// a zero gap runs the next burst back to back
				gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			req_valid <= 1'b0;
		end
	end

	// Receiver: switch now and then between no stall, random stall and a
	// periodic stall pattern.
	always @(negedge clk) begin
		int unsigned period;
		if (stall_left == 0) begin
			period       = $urandom_range(2, 20);
			stall_mode   <= $urandom_range(0, 2);
			stall_left   <= $urandom_range(50, 300);
			stall_period <= period;
			stall_on     <= $urandom_range(1, period - 1);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= ($urandom_range(0, 1) == 1);
			default: rsp_stall <= ((stall_left % stall_period) < stall_on);
		endcase
	end

	// Monitor: predict each request word when it is taken, and check each
	// result word against the oldest prediction.
	always @(posedge clk) begin
		placement_req_t w;
		placement_rsp_t want;
		placement_rsp_t due;
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			w.opcode    = opcode;
			w.rect_id   = rect_id;
			w.width     = width;
			w.height    = height;
			w.rotation  = rotation;
			w.ref_id    = reference_id;
			w.side      = side;
			w.alignment = alignment;
			due = place_rectangle(CHECK_COPY, w);
			results_due = {results_due, due};
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t: result word with none expected, status %0d", $time, status);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				compare_field("status", want.status, status);
				compare_field("placed_x", want.placed_x, placed_x);
				compare_field("placed_y", want.placed_y, placed_y);
				compare_field("conflict_slot", want.conflict_slot, conflict_slot);
				compare_field("entry_count", want.entry_count, entry_count);
				words_checked++;
				seen_status[want.status]++;
				if (want.status == rrp_pkg::STAT_ADDED && want.entry_count == MAX_RECTS)
					full_hits++;
			end
		end
	end

	// Stimulus: build the whole word list up front, then release reset and
	// wait for the block to drain.
	initial begin
		int unsigned random_sent;
		int unsigned tries;
		int unsigned n;
		// bad alignment on an empty table, then the origin entry
		schedule_word(make_clear());
		schedule_word(make_add(32'd0, 100, 60, 2'd0, 32'hFFFF_FFFF, rrp_pkg::SIDE_RIGHT,
			rrp_pkg::ALIGN_BAD));
		schedule_word(make_add(32'd0, 100, 60, 2'd0, 32'hFFFF_FFFF, rrp_pkg::SIDE_RIGHT,
			rrp_pkg::ALIGN_START));
		schedule_word(make_add(32'd0, 5, 5, 2'd0, 32'd0, rrp_pkg::SIDE_RIGHT,
			rrp_pkg::ALIGN_START));
		schedule_word(make_add(32'd1, 40, 20, 2'd0, 32'd12345, rrp_pkg::SIDE_ABOVE,
			rrp_pkg::ALIGN_START));
		// every side, every alignment, each rotation
		schedule_word(make_add(32'd1, 40, 20, 2'd0, 32'd0, rrp_pkg::SIDE_ABOVE,
			rrp_pkg::ALIGN_START));
		schedule_word(make_add(32'd2, 40, 20, 2'd1, 32'd0, rrp_pkg::SIDE_BELOW,
			rrp_pkg::ALIGN_END));
		schedule_word(make_add(32'd3, 30, 7, 2'd3, 32'd0, rrp_pkg::SIDE_LEFT,
			rrp_pkg::ALIGN_CENTRE));
		// negative odd centre offset truncates to zero and hits slot one
		schedule_word(make_add(32'd4, 101, 10, 2'd2, 32'd0, rrp_pkg::SIDE_ABOVE,
			rrp_pkg::ALIGN_CENTRE));
		schedule_word(make_add(32'd5, 9, 33, 2'd0, 32'd0, rrp_pkg::SIDE_RIGHT,
			rrp_pkg::ALIGN_CENTRE));
		// zero-size rectangle on the reference's edge does not overlap
		schedule_word(make_add(32'd6, 0, 0, 2'd0, 32'd0, rrp_pkg::SIDE_RIGHT,
			rrp_pkg::ALIGN_START));
		schedule_word(make_add(32'd7, 16383, 16383, 2'd0, 32'd1, rrp_pkg::SIDE_LEFT,
			rrp_pkg::ALIGN_END));
		schedule_word(make_add(32'hFFFF_FFFF, 16383, 1, 2'd1, 32'd7, rrp_pkg::SIDE_BELOW,
			rrp_pkg::ALIGN_START));
		schedule_word(make_add(32'd8, 100, 60, 2'd0, 32'd0, rrp_pkg::SIDE_ABOVE,
			rrp_pkg::ALIGN_START));
		schedule_word(make_add(32'd9, 16383, 16383, 2'd0, 32'd5, rrp_pkg::SIDE_RIGHT,
			rrp_pkg::ALIGN_END));
		// duplicate wins over bad alignment
		schedule_word(make_add(32'hFFFF_FFFF, 1, 1, 2'd0, 32'd0, rrp_pkg::SIDE_ABOVE,
			rrp_pkg::ALIGN_BAD));
		schedule_word(make_clear());
		schedule_word(make_add(32'd0, 1, 16383, 2'd3, 32'd0, rrp_pkg::SIDE_ABOVE,
			rrp_pkg::ALIGN_END));

		// random sessions: each starts with a clear; a third of them fill the
		// table and then push a few words against the full table
		random_sent = 0;
		while (random_sent < RANDOM_WORDS) begin
			schedule_word(make_clear());
			random_sent++;
			if ($urandom_range(0, 2) == 0) begin
				tries = 0;
				while (layout_fill[PLAN_COPY] < MAX_RECTS && tries < 200) begin
					schedule_word(random_add());
					tries++;
				end
				n = $urandom_range(1, 6);
				repeat (n) schedule_word(random_add());
				random_sent += tries + n;
			end else begin
				n = $urandom_range(1, 30);
				repeat (n) schedule_word(random_add());
				random_sent += n;
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || req_valid || results_due.size() != 0)
			@(posedge clk);
		// allow for a stray late word from the slowest add
		repeat (60) @(posedge clk);

		$display("Checked %0d result words: %0d added, %0d overlap, %0d no reference,",
			words_checked, seen_status[rrp_pkg::STAT_ADDED],
			seen_status[rrp_pkg::STAT_OVERLAP], seen_status[rrp_pkg::STAT_NO_REF]);
		$display("%0d duplicate, %0d bad alignment, %0d table full, %0d clears, %0d fills",
			seen_status[rrp_pkg::STAT_DUP], seen_status[rrp_pkg::STAT_BAD_ALIGN],
			seen_status[rrp_pkg::STAT_FULL], seen_status[rrp_pkg::STAT_CLEARED], full_hits);
		if (mismatches == 0) begin
			$display("tb_relative_rectangle_placer_unit passed");
		end else begin
			$display("tb_relative_rectangle_placer_unit failed");
		end
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#6000000;
		$display("%0t: timeout with %0d words unsent, %0d results due", $time,
			words_to_send.size(), results_due.size());
		$display("tb_relative_rectangle_placer_unit failed");
		$finish;
	end

endmodule
